/* design/sdd_pkg.sv */
// Shared constants and types for the segment-to-segment distance pipeline.
package sdd_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int DIST_WIDTH  = 25;

	localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

	typedef logic [1:0] case_t;

	localparam case_t CASE_INTERIOR  = 2'd0;
	localparam case_t CASE_CLAMPED   = 2'd1;
	localparam case_t CASE_PARALLEL  = 2'd2;
	localparam case_t CASE_DEGENERATE = 2'd3;

endpackage

/* design/sdd_div.sv */
// Pipelined restoring divider: one quotient bit per stage, floor(num * 2^(2F+2) / dvs).
module sdd_div #(
	parameter int COORD_WIDTH = sdd_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = sdd_pkg::FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [6*COORD_WIDTH+5:0]       num,
	input  logic [4*COORD_WIDTH+3:0]       dvs,
	output logic [2*COORD_WIDTH+2*FRAC_BITS+3:0] quo
);

	localparam int MW    = 4*COORD_WIDTH+4;
	localparam int QW    = 2*COORD_WIDTH+2*FRAC_BITS+4;
	localparam int SHIFT = 2*FRAC_BITS+2;

	logic [MW+QW-1:0] num_ext;
	logic [MW-1:0]    rem_s [QW];
	logic [QW-1:0]    lq_s  [QW];
	logic [MW-1:0]    dvs_s [QW];

	assign num_ext = {num, {SHIFT{1'b0}}};

	for (genvar j = 0; j < QW; j++) begin : g_st
		logic [MW-1:0] rem_p;
		logic [MW-1:0] dvs_p;
		logic [QW-1:0] lq_p;
		logic [MW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_p = num_ext[MW+QW-1:QW];
			assign lq_p  = num_ext[QW-1:0];
			assign dvs_p = dvs;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign lq_p  = lq_s[j-1];
			assign dvs_p = dvs_s[j-1];
		end

		assign trial = {rem_p, lq_p[QW-1]};
		assign take  = trial >= {1'b0, dvs_p};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? MW'(trial - {1'b0, dvs_p}) : trial[MW-1:0];
				lq_s[j]  <= {lq_p[QW-2:0], take};
				dvs_s[j] <= dvs_p;
			end
		end
	end

	assign quo = lq_s[QW-1];

endmodule

/* design/segment_segment_distance_3d.sv */
// Top level: minimum distance between two 3D segments, fully pipelined.
//
// Input channel: twelve signed endpoint coordinates with item_valid/item_stall.
// Output channel: distance (unsigned, FRAC_BITS fraction bits, rounded to
// nearest) and case_code with result_valid/result_stall.
// One beat in, one beat out, in order. A new beat can be taken every cycle while item_stall is low.
// The stages, with Q = 2*COORD_WIDTH + 2*FRAC_BITS + 4, are:
// 5 front stages (differences, dot/cross products, wide products, case
// decision, square of the triple product), Q divider stages (one quotient
// bit each), 1 minimum stage, Q/2 square-root stages (one root bit each)
// and the output register. With the defaults, Q = 52.
// Four dividers run side by side, one per endpoint-to-segment candidate;
// the first also serves the interior case.
// All stages advance together: while result_valid is high and result_stall
// is high the whole pipeline holds and item_stall is raised; nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
module segment_segment_distance_3d #(
	parameter int COORD_WIDTH = sdd_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = sdd_pkg::FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic signed [COORD_WIDTH-1:0]   a_start_x,
	input  logic signed [COORD_WIDTH-1:0]   a_start_y,
	input  logic signed [COORD_WIDTH-1:0]   a_start_z,
	input  logic signed [COORD_WIDTH-1:0]   a_end_x,
	input  logic signed [COORD_WIDTH-1:0]   a_end_y,
	input  logic signed [COORD_WIDTH-1:0]   a_end_z,
	input  logic signed [COORD_WIDTH-1:0]   b_start_x,
	input  logic signed [COORD_WIDTH-1:0]   b_start_y,
	input  logic signed [COORD_WIDTH-1:0]   b_start_z,
	input  logic signed [COORD_WIDTH-1:0]   b_end_x,
	input  logic signed [COORD_WIDTH-1:0]   b_end_y,
	input  logic signed [COORD_WIDTH-1:0]   b_end_z,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [sdd_pkg::DIST_WIDTH-1:0]  distance,
	output sdd_pkg::case_t                  case_code
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW+1;
	localparam int PW   = 2*CW+3;
	localparam int XW   = 2*CW+3;
	localparam int TW   = 3*CW+4;
	localparam int TAW  = 3*CW+3;
	localparam int HW   = (TAW+1)/2;
	localparam int SW   = 4*CW+6;
	localparam int MW   = 4*CW+4;
	localparam int NIW  = 2*TAW;
	localparam int QW   = 2*CW+2*FRAC_BITS+4;
	localparam int SQW  = QW/2;
	localparam int RW   = SQW+3;
	localparam int DSW  = sdd_pkg::DIST_WIDTH;
	localparam int CMPW = (SQW > DSW) ? SQW : DSW;

	typedef logic [2:0][CW-1:0] cvec_t;
	typedef logic [2:0][DW-1:0] dvec_t;
	typedef logic [2:0][XW-1:0] xvec_t;

	function automatic dvec_t sub3(input cvec_t x, input cvec_t y);
		dvec_t r;
		for (int i = 0; i < 3; i++) begin
			r[i] = DW'($signed(x[i])) - DW'($signed(y[i]));
		end
		return r;
	endfunction

	function automatic logic signed [PW-1:0] dot3(input dvec_t x, input dvec_t y);
		logic signed [PW-1:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			acc = acc + PW'($signed(x[i])) * PW'($signed(y[i]));
		end
		return acc;
	endfunction

	function automatic xvec_t cross3(input dvec_t x, input dvec_t y);
		xvec_t r;
		r[0] = XW'($signed(x[1])) * XW'($signed(y[2])) - XW'($signed(x[2])) * XW'($signed(y[1]));
		r[1] = XW'($signed(x[2])) * XW'($signed(y[0])) - XW'($signed(x[0])) * XW'($signed(y[2]));
		r[2] = XW'($signed(x[0])) * XW'($signed(y[1])) - XW'($signed(x[1])) * XW'($signed(y[0]));
		return r;
	endfunction

	logic adv;
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	// endpoints: a0, a1, b0, b1
	cvec_t ep [4];
	assign ep[0] = {a_start_z, a_start_y, a_start_x};
	assign ep[1] = {a_end_z, a_end_y, a_end_x};
	assign ep[2] = {b_start_z, b_start_y, b_start_x};
	assign ep[3] = {b_end_z, b_end_y, b_end_x};

	// valid bits
	logic           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [QW-1:0]  v_div_s;
	logic [SQW-1:0] sq_v_s;
	logic           result_valid_q;

	// stage 1: differences
	dvec_t u_s1, v_s1_d;
	dvec_t w_s1 [4];
	dvec_t x_s1 [4];

	// stage 2: dot and cross products
	logic signed [PW-1:0] aa_s2, bb_s2, cc_s2, dd_s2, ee_s2;
	xvec_t                nv_s2;
	dvec_t                w0_s2;
	logic signed [PW-1:0] proj_s2 [4];
	logic signed [PW-1:0] ww_s2 [4];
	logic signed [PW-1:0] xx_s2 [4];
	xvec_t                cr_s2 [4];

	// stage 3: wide products, candidate selection
	logic signed [SW-1:0] den_s3, sn_s3, tn_s3;
	logic signed [TW-1:0] t_s3;
	logic                 deg_s3;
	logic [NIW-1:0]       n_s3 [4];
	logic [MW-1:0]        m_s3 [4];

	// stage 4: case decision, partial squares
	sdd_pkg::case_t code_s4;
	logic [MW-1:0]  den_s4;
	logic [NIW-1:0] hh_s4, hl_s4, ll_s4;
	logic [NIW-1:0] n_s4 [4];
	logic [MW-1:0]  m_s4 [4];

	// stage 5: divider operands
	sdd_pkg::case_t code_s5;
	logic [NIW-1:0] num_s5 [4];
	logic [MW-1:0]  dvs_s5 [4];

	// divider outputs and side band
	logic [QW-1:0]  quo [4];
	sdd_pkg::case_t code_div_s [QW];

	// stage 6: minimum
	sdd_pkg::case_t code_s6;
	logic [QW-1:0]  q_s6;

	// square root
	logic [RW-1:0]  sq_rem_s  [SQW];
	logic [SQW-1:0] sq_root_s [SQW];
	logic [QW-1:0]  sq_rad_s  [SQW];
	sdd_pkg::case_t sq_code_s [SQW];

	// output register
	logic [DSW-1:0] distance_q;
	sdd_pkg::case_t case_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			v_div_s        <= '0;
			v_s6           <= 1'b0;
			sq_v_s         <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1           <= item_valid;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			v_s5           <= v_s4;
			v_div_s        <= {v_div_s[QW-2:0], v_s5};
			v_s6           <= v_div_s[QW-1];
			sq_v_s         <= {sq_v_s[SQW-2:0], v_s6};
			result_valid_q <= sq_v_s[SQW-1];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1   <= sub3(ep[1], ep[0]);
			v_s1_d <= sub3(ep[3], ep[2]);
			for (int k = 0; k < 4; k++) begin
				w_s1[k] <= sub3(ep[k], ep[(k < 2) ? 2 : 0]);
				x_s1[k] <= sub3(ep[k], ep[(k < 2) ? 3 : 1]);
			end
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (adv) begin
			aa_s2 <= dot3(u_s1, u_s1);
			bb_s2 <= dot3(u_s1, v_s1_d);
			cc_s2 <= dot3(v_s1_d, v_s1_d);
			dd_s2 <= dot3(u_s1, w_s1[0]);
			ee_s2 <= dot3(v_s1_d, w_s1[0]);
			nv_s2 <= cross3(u_s1, v_s1_d);
			w0_s2 <= w_s1[0];
			for (int k = 0; k < 4; k++) begin
				proj_s2[k] <= dot3(w_s1[k], (k < 2) ? v_s1_d : u_s1);
				ww_s2[k]   <= dot3(w_s1[k], w_s1[k]);
				xx_s2[k]   <= dot3(x_s1[k], x_s1[k]);
				cr_s2[k]   <= cross3((k < 2) ? v_s1_d : u_s1, w_s1[k]);
			end
		end
	end

	// stage 3
	logic [NIW-1:0] n_c [4];
	logic [MW-1:0]  m_c [4];

	always_comb begin
		logic signed [PW-1:0] len;
		logic signed [MW:0]   cs;
		for (int k = 0; k < 4; k++) begin
			len = (k < 2) ? cc_s2 : aa_s2;
			cs  = '0;
			for (int i = 0; i < 3; i++) begin
				cs = cs + (MW+1)'($signed(cr_s2[k][i])) * (MW+1)'($signed(cr_s2[k][i]));
			end
			if (len == '0 || proj_s2[k][PW-1] || proj_s2[k] == '0) begin
				n_c[k] = NIW'($unsigned(ww_s2[k]));
				m_c[k] = MW'(1);
			end else if (proj_s2[k] >= len) begin
				n_c[k] = NIW'($unsigned(xx_s2[k]));
				m_c[k] = MW'(1);
			end else begin
				n_c[k] = NIW'(cs[MW-1:0]);
				m_c[k] = MW'($unsigned(len));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s3 <= SW'(aa_s2) * SW'(cc_s2) - SW'(bb_s2) * SW'(bb_s2);
			sn_s3  <= SW'(bb_s2) * SW'(ee_s2) - SW'(cc_s2) * SW'(dd_s2);
			tn_s3  <= SW'(aa_s2) * SW'(ee_s2) - SW'(bb_s2) * SW'(dd_s2);
			t_s3   <= TW'($signed(w0_s2[0])) * TW'($signed(nv_s2[0]))
				+ TW'($signed(w0_s2[1])) * TW'($signed(nv_s2[1]))
				+ TW'($signed(w0_s2[2])) * TW'($signed(nv_s2[2]));
			deg_s3 <= (aa_s2 == '0) || (cc_s2 == '0);
			n_s3   <= n_c;
			m_s3   <= m_c;
		end
	end

	// stage 4
	sdd_pkg::case_t      code_c;
	logic signed [SW:0]  dms, dmt;
	logic [TW-1:0]       tmag;
	logic [TAW-HW-1:0]   th;
	logic [HW-1:0]       tl;

	always_comb begin
		dms = (SW+1)'(den_s3) - (SW+1)'(sn_s3);
		dmt = (SW+1)'(den_s3) - (SW+1)'(tn_s3);
		if (deg_s3) begin
			code_c = sdd_pkg::CASE_DEGENERATE;
		end else if (den_s3 == '0) begin
			code_c = sdd_pkg::CASE_PARALLEL;
		end else if (!sn_s3[SW-1] && !tn_s3[SW-1] && !dms[SW] && !dmt[SW]) begin
			code_c = sdd_pkg::CASE_INTERIOR;
		end else begin
			code_c = sdd_pkg::CASE_CLAMPED;
		end
		tmag = t_s3[TW-1] ? $unsigned(-t_s3) : $unsigned(t_s3);
		th   = tmag[TAW-1:HW];
		tl   = tmag[HW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s4 <= code_c;
			den_s4  <= den_s3[MW-1:0];
			hh_s4   <= NIW'(th) * NIW'(th);
			hl_s4   <= NIW'(th) * NIW'(tl);
			ll_s4   <= NIW'(tl) * NIW'(tl);
			n_s4    <= n_s3;
			m_s4    <= m_s3;
		end
	end

	// stage 5
	logic [NIW-1:0] tsq;
	assign tsq = (hh_s4 << (2*HW)) + (hl_s4 << (HW+1)) + ll_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s5 <= code_s4;
			for (int k = 0; k < 4; k++) begin
				if (k == 0 && code_s4 == sdd_pkg::CASE_INTERIOR) begin
					num_s5[k] <= tsq;
					dvs_s5[k] <= den_s4;
				end else begin
					num_s5[k] <= n_s4[k];
					dvs_s5[k] <= m_s4[k];
				end
			end
		end
	end

	// dividers
	for (genvar k = 0; k < 4; k++) begin : g_div
		sdd_div #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_div (
			.clk(clk),
			.en (adv),
			.num(num_s5[k]),
			.dvs(dvs_s5[k]),
			.quo(quo[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_div_s[0] <= code_s5;
			for (int j = 1; j < QW; j++) begin
				code_div_s[j] <= code_div_s[j-1];
			end
		end
	end

	// stage 6: least candidate, or divider 0 in the interior case
	logic [QW-1:0] qm01, qm23, qmin;
	always_comb begin
		qm01 = (quo[1] < quo[0]) ? quo[1] : quo[0];
		qm23 = (quo[3] < quo[2]) ? quo[3] : quo[2];
		qmin = (qm23 < qm01) ? qm23 : qm01;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s6 <= code_div_s[QW-1];
			q_s6    <= (code_div_s[QW-1] == sdd_pkg::CASE_INTERIOR) ? quo[0] : qmin;
		end
	end

	// square root, one root bit per stage
	for (genvar j = 0; j < SQW; j++) begin : g_sq
		logic [RW-1:0]  rem_p;
		logic [SQW-1:0] root_p;
		logic [QW-1:0]  rad_p;
		sdd_pkg::case_t code_p;
		logic [RW-1:0]  rem_x;
		logic [RW-1:0]  trial;
		logic           take;

		if (j == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = q_s6;
			assign code_p = code_s6;
		end else begin : g_next
			assign rem_p  = sq_rem_s[j-1];
			assign root_p = sq_root_s[j-1];
			assign rad_p  = sq_rad_s[j-1];
			assign code_p = sq_code_s[j-1];
		end

		assign rem_x = {rem_p[RW-3:0], rad_p[QW-1:QW-2]};
		assign trial = RW'({root_p, 2'b01});
		assign take  = rem_x >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[j]  <= take ? rem_x - trial : rem_x;
				sq_root_s[j] <= {root_p[SQW-2:0], take};
				sq_rad_s[j]  <= {rad_p[QW-3:0], 2'b00};
				sq_code_s[j] <= code_p;
			end
		end
	end

	// round and saturate
	logic [SQW:0]   rinc;
	logic [SQW-1:0] rnd;
	assign rinc = (SQW+1)'(sq_root_s[SQW-1]) + (SQW+1)'(1);
	assign rnd  = rinc[SQW:1];

	always_ff @(posedge clk) begin
		if (adv) begin
			case_code_q <= sq_code_s[SQW-1];
			if (CMPW'(rnd) > CMPW'(sdd_pkg::DIST_MAX)) begin
				distance_q <= sdd_pkg::DIST_MAX;
			end else begin
				distance_q <= DSW'(rnd);
			end
		end
	end

	assign result_valid = result_valid_q;
	assign distance     = distance_q;
	assign case_code    = case_code_q;

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> q_s6 < {2'b11, {(QW-2){1'b0}}})
		else $error("squared distance quotient out of range");

	a_interior_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && code_s4 == sdd_pkg::CASE_INTERIOR) |-> den_s4 != '0)
		else $error("interior case with zero determinant");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQW-1] |-> (RW'(sq_root_s[SQW-1]) << 1) >= sq_rem_s[SQW-1])
		else $error("square root remainder too large");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(v_s6) && $stable(q_s6)))
		else $error("pipeline moved while output stalled");

endmodule

/* tb/segment_segment_distance_3d_tb.sv */
// Testbench for segment_segment_distance_3d: exact-arithmetic distance predictor and scoreboard.
`timescale 1ns / 100ps

module segment_segment_distance_3d_tb;

	localparam int CW = sdd_pkg::COORD_WIDTH;
	localparam int LATENCY = 7 + 3 * (2 * CW + 2 * sdd_pkg::FRAC_BITS + 4) / 2;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t c[12];
	} seg_pair_t;
	typedef struct {
		logic [sdd_pkg::DIST_WIDTH-1:0] dist_val;
		sdd_pkg::case_t                 code;
	} dist_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	coord_t crd[12];
	logic result_valid;
	logic result_stall = 0;
	logic [sdd_pkg::DIST_WIDTH-1:0] distance;
	sdd_pkg::case_t case_code;

	dist_res_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	initial foreach (crd[i]) crd[i] = '0;

	segment_segment_distance_3d dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.a_start_x(crd[0]), .a_start_y(crd[1]), .a_start_z(crd[2]),
		.a_end_x(crd[3]), .a_end_y(crd[4]), .a_end_z(crd[5]),
		.b_start_x(crd[6]), .b_start_y(crd[7]), .b_start_z(crd[8]),
		.b_end_x(crd[9]), .b_end_y(crd[10]), .b_end_z(crd[11]),
		.result_valid(result_valid), .result_stall(result_stall),
		.distance(distance), .case_code(case_code)
	);

	initial forever #10 clk = ~clk;

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

	// round(sqrt(n/m) * 2^FRAC_BITS), saturated
	function automatic logic [sdd_pkg::DIST_WIDTH-1:0] fixed_root(logic [255:0] n,
			logic [255:0] m);
		logic [255:0] q;
		logic [127:0] res, bit_v, v;
		q = (n << (2 * sdd_pkg::FRAC_BITS + 2)) / m;
		if (q >= (256'd1 << 54)) return sdd_pkg::DIST_MAX;
		v = q[127:0];
		res = 0;
		bit_v = 128'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else res >>= 1;
			bit_v >>= 2;
		end
		res = (res + 1) >> 1;
		return (res > sdd_pkg::DIST_MAX) ? sdd_pkg::DIST_MAX : res[sdd_pkg::DIST_WIDTH-1:0];
	endfunction

	function automatic logic [sdd_pkg::DIST_WIDTH-1:0] point_to_segment(longint p[3],
			longint s[3], longint e[3]);
		longint d[3], w[3], x[3], len, proj;
		logic signed [255:0] n;
		foreach (d[i]) begin
			d[i] = e[i] - s[i];
			w[i] = p[i] - s[i];
			x[i] = p[i] - e[i];
		end
		len = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		proj = w[0]*d[0] + w[1]*d[1] + w[2]*d[2];
		if (len == 0 || proj <= 0)
			return fixed_root(256'(w[0]*w[0] + w[1]*w[1] + w[2]*w[2]), 256'(1));
		if (proj >= len)
			return fixed_root(256'(x[0]*x[0] + x[1]*x[1] + x[2]*x[2]), 256'(1));
		x[0] = d[1]*w[2] - d[2]*w[1];
		x[1] = d[2]*w[0] - d[0]*w[2];
		x[2] = d[0]*w[1] - d[1]*w[0];
		n = 256'(x[0])*256'(x[0]) + 256'(x[1])*256'(x[1]) + 256'(x[2])*256'(x[2]);
		return fixed_root(n, 256'(len));
	endfunction

	function automatic dist_res_t predict_distance(seg_pair_t sp);
		longint a0[3], a1[3], b0[3], b1[3], u[3], v[3], w[3], nv[3];
		longint aa, bb, cc, dd, ee;
		logic signed [255:0] den, sn, tn, trip;
		logic [sdd_pkg::DIST_WIDTH-1:0] k;
		dist_res_t r;
		for (int i = 0; i < 3; i++) begin
			a0[i] = longint'(sp.c[i]); a1[i] = longint'(sp.c[3+i]);
			b0[i] = longint'(sp.c[6+i]); b1[i] = longint'(sp.c[9+i]);
			u[i] = a1[i] - a0[i]; v[i] = b1[i] - b0[i]; w[i] = a0[i] - b0[i];
		end
		aa = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
		bb = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
		cc = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
		dd = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
		ee = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
		den = 256'(aa)*256'(cc) - 256'(bb)*256'(bb);
		r.code = sdd_pkg::CASE_CLAMPED;
		if (aa == 0 || cc == 0) r.code = sdd_pkg::CASE_DEGENERATE;
		else if (den == 0) r.code = sdd_pkg::CASE_PARALLEL;
		else begin
			sn = 256'(bb)*256'(ee) - 256'(cc)*256'(dd);
			tn = 256'(aa)*256'(ee) - 256'(bb)*256'(dd);
			if (sn >= 0 && tn >= 0 && sn <= den && tn <= den) r.code = sdd_pkg::CASE_INTERIOR;
		end
		if (r.code == sdd_pkg::CASE_INTERIOR) begin
			nv[0] = u[1]*v[2] - u[2]*v[1];
			nv[1] = u[2]*v[0] - u[0]*v[2];
			nv[2] = u[0]*v[1] - u[1]*v[0];
			trip = 256'(w[0])*256'(nv[0]) + 256'(w[1])*256'(nv[1]) + 256'(w[2])*256'(nv[2]);
			if (trip < 0) trip = -trip;
			r.dist_val = fixed_root(trip * trip, den);
		end else begin
			r.dist_val = point_to_segment(a0, b0, b1);
			k = point_to_segment(a1, b0, b1); if (k < r.dist_val) r.dist_val = k;
			k = point_to_segment(b0, a0, a1); if (k < r.dist_val) r.dist_val = k;
			k = point_to_segment(b1, a0, a1); if (k < r.dist_val) r.dist_val = k;
		end
		return r;
	endfunction

	task automatic send_pair(seg_pair_t sp);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		foreach (crd[i]) crd[i] <= sp.c[i];
		expected_q.push_back(predict_distance(sp));
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// receiver stall driver
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1;
		end else result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$display("%t: unexpected beat distance=%0d code=%0d", $time, distance,
					case_code);
				errors++;
			end else begin
				dist_res_t e;
				e = expected_q.pop_front();
				if (e.dist_val !== distance) begin
					$display("%t: distance expected %0d actual %0d", $time, e.dist_val,
						distance);
					errors++;
				end
				if (e.code !== case_code) begin
					$display("%t: case_code expected %0d actual %0d", $time, e.code,
						case_code);
					errors++;
				end
			end
		end
	end

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(40) - 20);
			default: return coord_t'($urandom_range(2000) - 1000);
		endcase
	endfunction

	task automatic test_directed();
		seg_pair_t sp;
		coord_t ext[4];
		ext = '{16'sh8000, 16'sh7fff, 0, -1};
		// crossing interior, skewed, clamped
		sp.c = '{0,0,0, 10,0,0, 5,-5,3, 5,5,3}; send_pair(sp);
		sp.c = '{0,0,0, 10,0,0, 20,-5,3, 20,5,7}; send_pair(sp);
		// parallel, collinear, overlapping
		sp.c = '{0,0,0, 10,0,0, 0,4,0, 10,4,0}; send_pair(sp);
		sp.c = '{0,0,0, 10,0,0, 20,0,0, 30,0,0}; send_pair(sp);
		sp.c = '{0,0,0, 10,0,0, 3,0,0, 7,0,0}; send_pair(sp);
		// degenerate: one point, both points, point on segment
		sp.c = '{1,2,3, 1,2,3, 0,0,0, 9,9,9}; send_pair(sp);
		sp.c = '{1,2,3, 1,2,3, 4,6,3, 4,6,3}; send_pair(sp);
		sp.c = '{0,0,0, 8,0,0, 4,0,0, 4,0,0}; send_pair(sp);
		// parameters exactly at ends (the first touching at an endpoint)
		sp.c = '{0,0,0, 10,0,0, 10,-5,0, 10,5,0}; send_pair(sp);
		sp.c = '{0,0,0, 10,0,0, 0,0,2, 0,10,2}; send_pair(sp);
		// full-scale extremes
		sp.c = '{ext[0],ext[0],ext[0], ext[1],ext[1],ext[1],
			ext[1],ext[0],ext[1], ext[0],ext[1],ext[0]}; send_pair(sp);
		sp.c = '{ext[0],ext[0],ext[0], ext[0],ext[0],ext[0],
			ext[1],ext[1],ext[1], ext[1],ext[1],ext[1]}; send_pair(sp);
		sp.c = '{ext[0],ext[1],ext[2], ext[3],ext[0],ext[1],
			ext[2],ext[3],ext[0], ext[1],ext[2],ext[3]}; send_pair(sp);
		sp.c = '{ext[1],0,0, ext[0],1,0, 0,ext[1],ext[0], 1,ext[0],ext[1]}; send_pair(sp);
	endtask

	task automatic test_random(int n);
		seg_pair_t sp;
		int mode, kind;
		repeat (n) begin
			mode = $urandom_range(2);
			kind = $urandom_range(9);
			foreach (sp.c[i]) sp.c[i] = rand_coord(mode);
			if (kind == 0) begin
				for (int i = 0; i < 3; i++) sp.c[3+i] = sp.c[i];
			end else if (kind == 1) begin
				for (int i = 0; i < 3; i++) sp.c[9+i] = sp.c[6+i] + (sp.c[3+i] - sp.c[i]) / 2;
			end else if (kind == 2) begin
				for (int i = 0; i < 3; i++) sp.c[9+i] = sp.c[6+i] + sp.c[i] - sp.c[3+i];
			end
			send_pair(sp);
		end
	endtask

	task automatic test_backpressure();
		seg_pair_t sp;
		hold_cycles = 300;
		repeat (200) begin
			foreach (sp.c[i]) sp.c[i] = rand_coord($urandom_range(2));
			send_pair(sp);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 7; recv_idle_pct = 59;
		test_random(600);
		send_idle_pct = 59; recv_idle_pct = 7;
		test_random(600);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		test_random(600);
		item_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
